// ===== rtl/core/hpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Horner polynomial evaluator package
// Shared widths, defaults and the item record passed between Horner steps.
// ----------------------------------------------------------------------------
package hpe_pkg;

   localparam int DATA_WIDTH         = 32;
   localparam int PROD_WIDTH         = 2 * DATA_WIDTH;
   localparam int NUM_COEFFS         = 8;
   localparam int CSR_INDEX_WIDTH    = $clog2(NUM_COEFFS);
   localparam int DEFAULT_MAX_DEGREE = 7;
   localparam int DEFAULT_FRAC_BITS  = 16;

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   typedef struct packed {
      data_type point;
      data_type acc;
      logic     sat;
   } hpe_item_type;

endpackage

// ===== rtl/core/hpe_step.sv =====
// ----------------------------------------------------------------------------
// Horner step
// One multiply-shift-add step in two register stages: the full product is
// registered, then shifted, summed with the coefficient and saturated.
// ----------------------------------------------------------------------------
module hpe_step #(
   parameter int FRAC_BITS = hpe_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hpe_pkg::hpe_item_type in_item,
   input  hpe_pkg::data_type    coeff,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hpe_pkg::hpe_item_type out_item
);
   import hpe_pkg::*;

   logic                         mul_valid_ff, mul_valid_in;
   logic                         mul_ready;
   logic signed [PROD_WIDTH-1:0] prod_ff, prod_in;
   data_type                     mul_point_ff;
   logic                         mul_sat_ff;

   logic                         add_valid_ff, add_valid_in;
   logic                         add_ready;
   hpe_item_type                 add_item_ff, add_item_in;

   logic signed [PROD_WIDTH-1:0] shifted;
   logic signed [PROD_WIDTH-1:0] sum;
   logic                         overflow;

   assign add_ready = !add_valid_ff || out_ready;
   assign mul_ready = !mul_valid_ff || add_ready;
   assign in_ready  = mul_ready;

   assign prod_in      = PROD_WIDTH'(in_item.acc) * PROD_WIDTH'(in_item.point);
   assign mul_valid_in = mul_ready ? in_valid : mul_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && in_valid) begin
         prod_ff      <= prod_in;
         mul_point_ff <= in_item.point;
         mul_sat_ff   <= in_item.sat;
      end
   end

   assign shifted  = prod_ff >>> FRAC_BITS;
   assign sum      = shifted + PROD_WIDTH'(coeff);
   assign overflow = !((&sum[PROD_WIDTH-1:DATA_WIDTH-1]) || !(|sum[PROD_WIDTH-1:DATA_WIDTH-1]));

   always_comb begin
      add_item_in.point = mul_point_ff;
      add_item_in.sat   = mul_sat_ff || overflow;
      if (!overflow) begin
         add_item_in.acc = sum[DATA_WIDTH-1:0];
      end else if (sum[PROD_WIDTH-1]) begin
         add_item_in.acc = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      end else begin
         add_item_in.acc = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end
   end

   assign add_valid_in = add_ready ? mul_valid_ff : add_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         add_valid_ff <= 1'b0;
      end else begin
         add_valid_ff <= add_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (add_ready && mul_valid_ff) begin
         add_item_ff <= add_item_in;
      end
   end

   assign out_valid = add_valid_ff;
   assign out_item  = add_item_ff;

endmodule

// ===== rtl/core/horner_polynomial_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// Horner polynomial evaluator unit
// Evaluates p(x) = c7*x^7 + ... + c0 in signed Q16.16 by Horner's rule.
//
// A request on req_ carries one point x; one response on rsp_ returns the
// value p(x), saturated to 32 bits after every step, and a flag set when any
// step saturated. Coefficients are written on the csr_ channel, index 0 for
// the constant term up to index 7; csr_ready is always high. Write them only
// while no request is in flight.
// Each of the MAX_DEGREE Horner steps has a multiply stage and a
// shift-add-saturate stage. One request is taken per cycle while the
// receiver does not stall. The last stage is the output register. When
// the receiver stalls, the pipeline fills its empty stages and then holds
// req_ready low; nothing is dropped or repeated.
// Reset clears all pipeline valid bits and sets every coefficient to zero.
// ----------------------------------------------------------------------------
module horner_polynomial_evaluator_unit #(
   parameter int MAX_DEGREE = hpe_pkg::DEFAULT_MAX_DEGREE,
   parameter int FRAC_BITS  = hpe_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [hpe_pkg::DATA_WIDTH-1:0] req_point,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [hpe_pkg::DATA_WIDTH-1:0] rsp_value,
   output logic                                rsp_saturated,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hpe_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [hpe_pkg::DATA_WIDTH-1:0]       csr_data
);
   import hpe_pkg::*;

   data_type     coeff_ff [NUM_COEFFS];
   logic         stage_valid [MAX_DEGREE+1];
   logic         stage_ready [MAX_DEGREE+1];
   hpe_item_type stage_item  [MAX_DEGREE+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_COEFFS; k++) begin
            coeff_ff[k] <= '0;
         end
      end else if (csr_valid) begin
         coeff_ff[csr_index] <= csr_data;
      end
   end

   assign stage_valid[0]      = req_valid;
   assign req_ready           = stage_ready[0];
   assign stage_item[0].point = req_point;
   assign stage_item[0].acc   = coeff_ff[CSR_INDEX_WIDTH'(MAX_DEGREE)];
   assign stage_item[0].sat   = 1'b0;

   for (genvar j = 0; j < MAX_DEGREE; j++) begin : g_step
      hpe_step #(
         .FRAC_BITS (FRAC_BITS)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[j]),
         .in_ready  (stage_ready[j]),
         .in_item   (stage_item[j]),
         .coeff     (coeff_ff[CSR_INDEX_WIDTH'(MAX_DEGREE - 1 - j)]),
         .out_valid (stage_valid[j+1]),
         .out_ready (stage_ready[j+1]),
         .out_item  (stage_item[j+1])
      );
   end

   assign stage_ready[MAX_DEGREE] = rsp_ready;
   assign rsp_valid               = stage_valid[MAX_DEGREE];
   assign rsp_value               = stage_item[MAX_DEGREE].acc;
   assign rsp_saturated           = stage_item[MAX_DEGREE].sat;

endmodule
